@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/snt_pkg.sv @@
// Package for the Smith number test unit: widths, limits and arithmetic constants.
// No dependencies.
package snt_pkg;

  localparam int NUMBER_WIDTH_DEF = 31;
  localparam int DIGIT_SUM_W      = 7;
  localparam int FACTOR_SUM_W     = 8;
  localparam int DIGIT_ACC_W      = 8;   // digit sum of a 63-bit value stays below 256
  localparam int FACTOR_CNT_W     = 2;

  localparam logic [DIGIT_SUM_W-1:0]  DIGIT_SUM_MAX  = 7'd127;
  localparam logic [FACTOR_SUM_W-1:0] FACTOR_SUM_MAX = 8'd255;
  localparam logic [FACTOR_CNT_W-1:0] FACTOR_CNT_SAT = 2'd2;

  localparam int DECIMAL_BASE   = 10;
  localparam int FIRST_DIVISOR  = 2;
  localparam int SECOND_DIVISOR = 3;
  localparam int ODD_STRIDE     = 2;

endpackage

@@ hw/rtl/smith_number_test_unit.sv @@
// Smith number test unit: divisions run one divide step a cycle. A number takes one
// division per decimal digit of the number, per trial division and per decimal digit of
// each prime factor before the result transfer; trials run over 2 and the odd divisors up
// to the square root of the cofactor.
// A new number is taken only once the last one is through; busy stays high until the result.
// Reset (rst_n low, synchronous) drops any number in flight; no result is left pending.
`include "assert_macros.svh"

module smith_number_test_unit #(
  parameter int NUMBER_WIDTH = snt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [NUMBER_WIDTH-1:0]           in_number,
  output logic                              out_valid,
  output logic                              out_is_smith,
  output logic                              out_is_composite,
  output logic [snt_pkg::DIGIT_SUM_W-1:0]   out_digit_sum,
  output logic [snt_pkg::FACTOR_SUM_W-1:0]  out_factor_digit_sum
);
  import snt_pkg::*;

  localparam int CNT_W = $clog2(NUMBER_WIDTH);
  localparam logic [CNT_W-1:0]        LAST_STEP = CNT_W'(NUMBER_WIDTH - 1);
  localparam logic [NUMBER_WIDTH-1:0] TEN       = NUMBER_WIDTH'(DECIMAL_BASE);
  localparam logic [NUMBER_WIDTH-1:0] ONE       = NUMBER_WIDTH'(1);
  localparam logic [NUMBER_WIDTH-1:0] DIV_FIRST = NUMBER_WIDTH'(FIRST_DIVISOR);
  localparam logic [NUMBER_WIDTH-1:0] DIV_THIRD = NUMBER_WIDTH'(SECOND_DIVISOR);
  localparam logic [NUMBER_WIDTH-1:0] DIV_STEP  = NUMBER_WIDTH'(ODD_STRIDE);

  // Sequencer phases:
  //   S_IDLE  wait for a start transfer
  //   S_DSUM  digit sum of the number by repeated division by ten
  //   S_TRIAL divide the cofactor by the current trial divisor
  //   S_FSUM  digit sum of a prime factor (divisor, or the final cofactor)
  //   S_DONE  present the result for one cycle
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DSUM  = 5'b00010,
    S_TRIAL = 5'b00100,
    S_FSUM  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;      // divide step within a division
  logic [NUMBER_WIDTH-1:0]   rem_r, rem_nxt;      // partial remainder
  logic [NUMBER_WIDTH-1:0]   quo_r, quo_nxt;      // dividend shifting out, quotient shifting in
  logic [NUMBER_WIDTH-1:0]   dvs_r, dvs_nxt;      // divisor of the running division
  logic [NUMBER_WIDTH-1:0]   rest_r, rest_nxt;    // number, then remaining cofactor
  logic [NUMBER_WIDTH-1:0]   dvr_r, dvr_nxt;      // current trial divisor
  logic [DIGIT_ACC_W-1:0]    acc_r, acc_nxt;      // digit sum in progress
  logic [DIGIT_SUM_W-1:0]    dsum_r, dsum_nxt;
  logic [FACTOR_SUM_W-1:0]   fsum_r, fsum_nxt;
  logic [FACTOR_CNT_W-1:0]   fac_r, fac_nxt;      // prime factor count, saturating
  logic                      tail_r, tail_nxt;    // digit sum under way is the final cofactor

  // Shared restoring divider step.
  logic [NUMBER_WIDTH:0]     shifted;
  logic [NUMBER_WIDTH:0]     diff;
  logic                      fits;
  logic [NUMBER_WIDTH-1:0]   step_rem;
  logic [NUMBER_WIDTH-1:0]   step_quo;
  logic                      last_step;

  // Loading a new division.
  logic                      load_en;
  logic [NUMBER_WIDTH-1:0]   load_dividend;
  logic [NUMBER_WIDTH-1:0]   load_divisor;

  logic [DIGIT_ACC_W-1:0]    digit_add;
  logic [FACTOR_SUM_W:0]     fsum_add;
  logic [FACTOR_SUM_W-1:0]   fsum_sat;
  logic [DIGIT_SUM_W-1:0]    dsum_sat;

  always_comb begin
    shifted   = {rem_r, quo_r[NUMBER_WIDTH-1]};
    diff      = shifted - {1'b0, dvs_r};
    fits      = !diff[NUMBER_WIDTH];
    step_rem  = fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
    step_quo  = {quo_r[NUMBER_WIDTH-2:0], fits};
    last_step = (cnt_r == LAST_STEP);

    // A finished division by ten leaves a remainder below ten.
    digit_add = acc_r + DIGIT_ACC_W'(step_rem[3:0]);
    fsum_add  = {1'b0, fsum_r} + (FACTOR_SUM_W+1)'(digit_add);
    fsum_sat  = (fsum_add > (FACTOR_SUM_W+1)'(FACTOR_SUM_MAX)) ? FACTOR_SUM_MAX
                                                              : fsum_add[FACTOR_SUM_W-1:0];
    dsum_sat  = (digit_add > DIGIT_ACC_W'(DIGIT_SUM_MAX)) ? DIGIT_SUM_MAX
                                                          : digit_add[DIGIT_SUM_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    rest_nxt      = rest_r;
    dvr_nxt       = dvr_r;
    acc_nxt       = acc_r;
    dsum_nxt      = dsum_r;
    fsum_nxt      = fsum_r;
    fac_nxt       = fac_r;
    tail_nxt      = tail_r;
    load_en       = 1'b0;
    load_dividend = rest_r;
    load_divisor  = TEN;

    // Advance the running division by one quotient bit; wrap the step count after the last.
    if (state_r == S_DSUM || state_r == S_TRIAL || state_r == S_FSUM) begin
      rem_nxt = step_rem;
      quo_nxt = step_quo;
      cnt_nxt = last_step ? '0 : cnt_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rest_nxt      = in_number;
          acc_nxt       = '0;
          fsum_nxt      = '0;
          fac_nxt       = '0;
          tail_nxt      = 1'b0;
          load_en       = 1'b1;
          load_dividend = in_number;
          state_nxt     = S_DSUM;
        end
      end
      S_DSUM: begin
        if (last_step) begin
          if (step_quo != '0) begin
            acc_nxt       = digit_add;
            load_en       = 1'b1;
            load_dividend = step_quo;
          end else begin
            dsum_nxt = dsum_sat;
            if (rest_r > ONE) begin
              dvr_nxt       = DIV_FIRST;
              load_en       = 1'b1;
              load_divisor  = DIV_FIRST;
              state_nxt     = S_TRIAL;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_TRIAL: begin
        if (last_step) begin
          acc_nxt = '0;
          if (step_quo < dvr_r) begin
            // Divisor squared exceeds the cofactor: what is left is prime.
            tail_nxt  = 1'b1;
            load_en   = 1'b1;
            state_nxt = S_FSUM;
          end else if (step_rem == '0) begin
            rest_nxt      = step_quo;
            load_en       = 1'b1;
            load_dividend = dvr_r;
            state_nxt     = S_FSUM;
          end else begin
            // Try 2, then odd divisors only.
            dvr_nxt      = (dvr_r == DIV_FIRST) ? DIV_THIRD : dvr_r + DIV_STEP;
            load_en      = 1'b1;
            load_divisor = dvr_nxt;
          end
        end
      end
      S_FSUM: begin
        if (last_step) begin
          if (step_quo != '0) begin
            acc_nxt       = digit_add;
            load_en       = 1'b1;
            load_dividend = step_quo;
          end else begin
            fsum_nxt = fsum_sat;
            if (fac_r != FACTOR_CNT_SAT) begin
              fac_nxt = fac_r + FACTOR_CNT_W'(1);
            end
            if (tail_r || rest_r <= ONE) begin
              state_nxt = S_DONE;
            end else begin
              load_en      = 1'b1;
              load_divisor = dvr_r;
              state_nxt    = S_TRIAL;
            end
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start a fresh division: clear the remainder and the step count.
    if (load_en) begin
      quo_nxt = load_dividend;
      dvs_nxt = load_divisor;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fac_r   <= '0;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fac_r   <= fac_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    rest_r <= rest_nxt;
    dvr_r  <= dvr_nxt;
    acc_r  <= acc_nxt;
    dsum_r <= dsum_nxt;
    fsum_r <= fsum_nxt;
  end

  // Result transfer: one cycle in S_DONE, straight from the accumulators.
  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_DONE);
  assign out_is_composite     = (fac_r == FACTOR_CNT_SAT);
  assign out_is_smith         = out_is_composite && (fsum_r == {1'b0, dsum_r});
  assign out_digit_sum        = dsum_r;
  assign out_factor_digit_sum = fsum_r;

  `ASSERT_CLK(a_accept_goes_busy, start && !busy |=> busy && !out_valid, "accepted item did not start")
  `ASSERT_CLK(a_done_then_idle, out_valid |=> !busy, "result strobe longer than one cycle")
  `ASSERT_CLK(a_smith_is_composite, out_valid && out_is_smith |-> out_is_composite, "smith flag without composite")
  `ASSERT_CLK(a_trial_divisor_form, state_r == S_TRIAL |-> dvr_r[0] || dvr_r == DIV_FIRST, "even trial divisor above two")
  `ASSERT_NEVER(a_step_count_range, cnt_r > LAST_STEP, "divide step count out of range")

endmodule

@@ test/tb_smith_number_test_unit.sv @@
// Testbench for smith_number_test_unit: drives numbers through the start/busy command port and
// checks every strobed result against a trial-division predictor held here.
// Depends on snt_pkg and the smith_number_test_unit RTL only.
module tb_smith_number_test_unit;

  localparam int          NUM_W           = snt_pkg::NUMBER_WIDTH_DEF;
  localparam longint      NUM_MAX         = (longint'(1) << NUM_W) - 1;
  localparam int          RANDOM_ITEMS    = 80;
  // Limit on the run of cycles with neither a number nor a result transfer before giving up.
  localparam int unsigned WATCHDOG_LIMIT  = 2_500_000;
  // Quiet cycles after the last result; any strobe in this window has no number behind it.
  localparam int          DRAIN_CYCLES    = 64;

  // One classification, laid out like the result ports.
  typedef struct packed {
    logic                             is_smith;
    logic                             is_composite;
    logic [snt_pkg::DIGIT_SUM_W-1:0]  digit_sum;
    logic [snt_pkg::FACTOR_SUM_W-1:0] factor_digit_sum;
  } smith_verdict_t;

  logic                             clk;
  logic                             rst_n   = 1'b0;
  logic                             start   = 1'b0;
  logic [NUM_W-1:0]                 in_number = '0;
  logic                             busy;
  logic                             out_valid;
  logic                             out_is_smith;
  logic                             out_is_composite;
  logic [snt_pkg::DIGIT_SUM_W-1:0]  out_digit_sum;
  logic [snt_pkg::FACTOR_SUM_W-1:0] out_factor_digit_sum;

  // Numbers waiting to be offered; the front one is what start presents until it transfers.
  logic [NUM_W-1:0] number_q[$];
  // Predicted verdicts of numbers already taken by the block, oldest first.
  smith_verdict_t   verdict_q[$];

  int          total_numbers;
  int          directed_numbers;
  int          numbers_taken;
  int          results_seen;
  int          smith_seen;
  int          composite_seen;
  int          error_count;
  int unsigned quiet_cycles;

  smith_number_test_unit #(
    .NUMBER_WIDTH(NUM_W)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_number           (in_number),
    .out_valid           (out_valid),
    .out_is_smith        (out_is_smith),
    .out_is_composite    (out_is_composite),
    .out_digit_sum       (out_digit_sum),
    .out_factor_digit_sum(out_factor_digit_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sum of decimal digits of any value the predictor meets.
  function automatic int unsigned decimal_digit_total(longint unsigned v);
    int unsigned total;
    total = 0;
    while (v != 0) begin
      total += int'(v % snt_pkg::DECIMAL_BASE);
      v /= snt_pkg::DECIMAL_BASE;
    end
    return total;
  endfunction

  // Classify one number: digit sum, prime factors by trial division with multiplicity,
  // and the Smith test. Zero yields an all-zero verdict; one has no prime factors.
  function automatic smith_verdict_t classify_number(longint unsigned raw);
    smith_verdict_t  verdict;
    longint unsigned n;
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     dsum;
    int unsigned     fsum;
    int unsigned     prime_count;
    n           = raw & longint'(NUM_MAX);
    dsum        = 0;
    fsum        = 0;
    prime_count = 0;
    verdict     = '0;
    if (n != 0) begin
      dsum = decimal_digit_total(n);
      if (dsum > snt_pkg::DIGIT_SUM_MAX) dsum = snt_pkg::DIGIT_SUM_MAX;
      rest    = n;
      divisor = snt_pkg::FIRST_DIVISOR;
      // Stop once the divisor squared passes the cofactor; what is left is prime.
      while (rest > 1 && divisor <= rest / divisor) begin
        if (rest % divisor == 0) begin
          rest /= divisor;
          fsum += decimal_digit_total(divisor);
          prime_count++;
        end else begin
          divisor++;
        end
        if (fsum > snt_pkg::FACTOR_SUM_MAX) fsum = snt_pkg::FACTOR_SUM_MAX;
      end
      if (rest > 1) begin
        fsum += decimal_digit_total(rest);
        prime_count++;
        if (fsum > snt_pkg::FACTOR_SUM_MAX) fsum = snt_pkg::FACTOR_SUM_MAX;
      end
      verdict.is_composite     = (prime_count >= 2);
      verdict.is_smith         = verdict.is_composite && (fsum == dsum);
      verdict.digit_sum        = dsum[snt_pkg::DIGIT_SUM_W-1:0];
      verdict.factor_digit_sum = fsum[snt_pkg::FACTOR_SUM_W-1:0];
    end
    return verdict;
  endfunction

  // Compare one result field and log the mismatch with both values.
  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Driver: present the front number with start, hold it while busy, and pop it on the
  // transfer. The sender idles 13% of the time in the first third of the run, 72% in the
  // second and never in the last.
  always @(posedge clk) begin : number_driver
    logic taken;
    int   idle_pct;
    if (!rst_n) begin
      start     <= 1'b0;
      in_number <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        verdict_q.insert(verdict_q.size(), classify_number(longint'(in_number)));
        void'(number_q.pop_front());
        numbers_taken++;
      end
      if (numbers_taken < total_numbers / 3)          idle_pct = 13;
      else if (numbers_taken < 2 * total_numbers / 3) idle_pct = 72;
      else                                            idle_pct = 0;
      if (start && !taken) begin
        // hold the offered number until the block takes it
      end else if (number_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        start     <= 1'b1;
        in_number <= number_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobe retires the oldest prediction, field by field.
  always @(posedge clk) begin : verdict_monitor
    smith_verdict_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_is_smith)     smith_seen++;
      if (out_is_composite) composite_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with no number outstanding, actual smith=%0b composite=%0b",
                 $time, out_is_smith, out_is_composite);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("is_smith",         want.is_smith,         out_is_smith);
        check_field("is_composite",     want.is_composite,     out_is_composite);
        check_field("digit_sum",        want.digit_sum,        out_digit_sum);
        check_field("factor_digit_sum", want.factor_digit_sum, out_factor_digit_sum);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin : stall_watchdog
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else                                        quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d numbers and %0d results outstanding",
               $time, quiet_cycles, number_q.size(), verdict_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned directed_list[$];
    longint unsigned smith_seeds[$];
    longint unsigned value;
    longint unsigned factor;
    int              pick;
    directed_list = '{
      0,            // below the range: all fields zero
      1,            // neither prime nor composite
      2, 3, 97,     // small primes
      4, 22, 27,    // smallest Smith numbers
      9, 49, 121,   // prime squares
      666, 4937775, // larger Smith numbers
      999999999,    // large cofactor after small factors
      1162261467,   // a pure prime power
      715827882,    // alternating bits, even
      1431655765,   // alternating bits, odd
      1073741823,   // all low bits set
      1073741824,   // top bit alone
      2147483646,   // field maximum minus one, smooth
      2147483647    // field maximum, a prime: the slowest case
    };
    smith_seeds = '{58, 85, 94, 166, 202, 265, 274, 319, 346, 355, 378, 382, 391, 438,
                    454, 483, 517, 526, 535, 562, 576, 588, 627, 634, 636, 645};
    error_count    = 0;
    numbers_taken  = 0;
    results_seen   = 0;
    smith_seen     = 0;
    composite_seen = 0;
    quiet_cycles   = 0;

    foreach (directed_list[i]) number_q.insert(number_q.size(), directed_list[i][NUM_W-1:0]);
    directed_numbers = number_q.size();

    // Keep most numbers small or smooth so trial division stays short; products of
    // small factors reach the upper bits without long searches.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        value = $urandom_range(4095, 2);
      end else if (pick < 58) begin
        value = $urandom_range(65535, 4096);
      end else if (pick < 83) begin
        value = 1;
        forever begin
          factor = $urandom_range(199, 2);
          if (value * factor > NUM_MAX) break;
          value = value * factor;
          if ($urandom_range(11, 0) == 0) break;
        end
      end else if (pick < 88) begin
        value = $urandom_range(1 << 20, 65536);
      end else if (pick < 94) begin
        value = longint'($urandom_range(127, 1)) << $urandom_range(23, 0);
      end else begin
        value = smith_seeds[$urandom_range(smith_seeds.size() - 1, 0)];
      end
      number_q.insert(number_q.size(), value[NUM_W-1:0]);
    end
    total_numbers = number_q.size();

    // Hold reset, then release it for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Advance until every number has transferred and every verdict has been retired.
    while (number_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Classified %0d numbers (%0d directed, %0d random) with %0d results back.",
             numbers_taken, directed_numbers, total_numbers - directed_numbers, results_seen);
    $display("Results held %0d Smith and %0d composite numbers; %0d field mismatches.",
             smith_seen, composite_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
